@@ hdl/mavg_pkg.sv @@
// ----------------------------------------------------------------------------
// mavg_pkg
// shared constants, controller states and control structs for the moving
// average block
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // window size register and sample count field are fixed width
    localparam int WSIZE_BITS = 7;
    localparam int HELD_BITS  = 7;

    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(4);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIV
    } t_state;

    typedef struct packed {
        logic capture;    // latch sample, read oldest ring entry
        logic update;     // ring write, running sum and count update
        logic div_start;  // load divider from running sum and count
        logic out_load;   // move quotient into output register
    } t_dp_cmd;

    typedef struct packed {
        logic div_idle;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/mavg_in_if.sv @@
// ----------------------------------------------------------------------------
// mavg_in_if
// sample channel: valid/ready handshake with one signed sample
// ----------------------------------------------------------------------------
interface mavg_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/mavg_out_if.sv @@
// ----------------------------------------------------------------------------
// mavg_out_if
// result channel: valid/ready handshake with mean and sample count
// ----------------------------------------------------------------------------
interface mavg_out_if #(
    parameter int MEAN_BITS = 24,
    parameter int HELD_BITS = 7
);
    logic                        valid;
    logic                        ready;
    logic signed [MEAN_BITS-1:0] mean;
    logic [HELD_BITS-1:0]        samples_held;

    modport source (output valid, output mean, output samples_held, input ready);
    modport sink   (input valid, input mean, input samples_held, output ready);
endinterface

@@ hdl/moving_average_running_sum_top.sv @@
// ----------------------------------------------------------------------------
// moving_average_running_sum_top
// sliding window moving average over a sample ring with a running sum
//
//   channel       dir   handshake      payload
//   i_sample_ch   in    valid/ready    sample
//   o_result_ch   out   valid/ready    mean, samples_held
//   i_cfg_wr_*    in    write enable   window size
//
// each item steps through capture with ring read, sum update, divider load,
// then the restoring divider, which yields one quotient bit per cycle.
// a new sample is taken while the previous result waits in the output
// register; a stalled result holds the last cycle of the division.
// reset is synchronous; window size goes to min(4, WINDOW_MAX), window empties.
// ----------------------------------------------------------------------------
module moving_average_running_sum_top #(
    parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mavg_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mavg_pkg::WSIZE_BITS-1:0] i_cfg_wr_data,
    mavg_in_if.sink                         i_sample_ch,
    mavg_out_if.source                      o_result_ch
);
    import mavg_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    mavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .o_in_ready (i_sample_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mavg_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample       (i_sample_ch.sample),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_result_ch.ready),
        .o_out_valid    (o_result_ch.valid),
        .o_mean         (o_result_ch.mean),
        .o_samples_held (o_result_ch.samples_held)
    );

endmodule

@@ hdl/mavg_div.sv @@
// ----------------------------------------------------------------------------
// mavg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mavg_div #(
    parameter int DVD_W = 31,
    parameter int DVS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_idle,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] rem_sub;
    logic           ge;

    // dividend bits shift out of the top while quotient bits shift in below
    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_idle     = !r_busy;
    assign o_quotient = r_quo;

endmodule

@@ hdl/mavg_dp.sv @@
// ----------------------------------------------------------------------------
// mavg_dp
// datapath: sample ring, running sum, fill count, divider and result register
// ----------------------------------------------------------------------------
module mavg_dp #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [mavg_pkg::WSIZE_BITS-1:0]         i_cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample,
    input  mavg_pkg::t_dp_cmd                       i_cmd,
    output mavg_pkg::t_dp_status                    o_status,
    input  logic                                    i_out_ready,
    output logic                                    o_out_valid,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] o_mean,
    output logic [mavg_pkg::HELD_BITS-1:0]          o_samples_held
);
    import mavg_pkg::*;

    localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_W     = SAMPLE_BITS + WSIZE_BITS;
    localparam int DVD_W     = SUM_W + FRAC_BITS;
    localparam int SLOT_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W     = (SLOT_W + 1 > WSIZE_BITS) ? SLOT_W + 1 : WSIZE_BITS;

    // reset window size, held within the ring depth
    localparam logic [WSIZE_BITS-1:0] WIN_RESET =
        (WINDOW_MAX < int'(WSIZE_RESET)) ? WSIZE_BITS'(WINDOW_MAX) : WSIZE_RESET;

    logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

    logic [WSIZE_BITS-1:0]         r_win;
    logic [HELD_BITS-1:0]          r_fill;
    logic [SLOT_W-1:0]             r_slot;
    logic signed [SUM_W-1:0]       r_total;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_old;
    logic                          r_neg;
    logic                          r_out_valid;
    logic signed [MEAN_BITS-1:0]   r_mean;
    logic [HELD_BITS-1:0]          r_held;

    logic                          full;
    logic [SLOT_W:0]               slot_inc;
    logic                          slot_wrap;
    logic signed [SUM_W-1:0]       n_total;
    logic signed [DVD_W-1:0]       scaled;
    logic [DVD_W-1:0]              mag;
    logic                          div_idle;
    logic [DVD_W-1:0]              quo;
    logic [DVD_W-1:0]              quo_signed;
    logic                          out_free;

    assign full      = (HELD_BITS'(r_win) == r_fill);
    assign slot_inc  = {1'b0, r_slot} + 1'b1;
    assign slot_wrap = (CMP_W'(slot_inc) >= CMP_W'(r_win));
    assign n_total   = r_total + SUM_W'(r_sample) - (full ? SUM_W'(r_old) : '0);

    // divide the magnitude, restore the sign after: truncation toward zero
    assign scaled = DVD_W'(r_total) <<< FRAC_BITS;
    assign mag    = scaled[DVD_W-1] ? DVD_W'(-scaled) : DVD_W'(scaled);

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_old    <= mem[r_slot];
            r_sample <= i_sample;
        end
        if (i_cmd.update) begin
            mem[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= WIN_RESET;
            r_fill  <= '0;
            r_slot  <= '0;
            r_total <= '0;
        end else if (i_cfg_wr_en) begin
            // zero means a window of one, oversize saturates
            if (i_cfg_wr_data == '0) begin
                r_win <= WSIZE_BITS'(1);
            end else if (32'(i_cfg_wr_data) > WINDOW_MAX) begin
                r_win <= WSIZE_BITS'(WINDOW_MAX);
            end else begin
                r_win <= i_cfg_wr_data;
            end
            r_fill  <= '0;
            r_slot  <= '0;
            r_total <= '0;
        end else if (i_cmd.update) begin
            r_total <= n_total;
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
            r_slot <= slot_wrap ? '0 : slot_inc[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_total[SUM_W-1];
        end
    end

    mavg_div #(
        .DVD_W (DVD_W),
        .DVS_W (HELD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (r_fill),
        .o_idle     (div_idle),
        .o_quotient (quo)
    );

    assign quo_signed = r_neg ? (~quo + 1'b1) : quo;

    // result register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean <= quo_signed[MEAN_BITS-1:0];
            r_held <= r_fill;
        end
    end

    assign o_status.div_idle = div_idle;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_mean            = r_mean;
    assign o_samples_held    = r_held;

endmodule

@@ hdl/mavg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mavg_ctrl
// controller: sequences capture, update, division and result hand-off
// ----------------------------------------------------------------------------
module mavg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mavg_pkg::t_dp_status i_status,
    output mavg_pkg::t_dp_cmd    o_cmd
);
    import mavg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                // wait for the quotient and for room in the result register
                if (i_status.div_idle && i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
            end
            S_DIV: begin
                o_cmd.out_load = i_status.div_idle && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
